/* design/tcw_pkg.sv */
package tcw_pkg;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } tcw_in_t;

  typedef struct packed {
    logic signed [31:0] cot_at_a;
    logic signed [31:0] cot_at_b;
    logic signed [31:0] cot_at_c;
    logic [1:0]         status;
  } tcw_out_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_COS   = 2'd2;
  localparam logic [1:0] ST_SINE  = 2'd3;

  localparam int IdxW = 2;
  localparam logic [IdxW-1:0] REG_MIN_EDGE_SQ = 2'd0;
  localparam logic [IdxW-1:0] REG_MIN_SINE    = 2'd1;

  // Multiplier operand and product widths.
  localparam int MW = 66;
  localparam int SW = 2 * MW;
  localparam int MulLat = 2;

  localparam int DivSteps  = 62;
  localparam int SqrtSteps = 32;
  localparam int CotLat    = DivSteps + SqrtSteps + 2;

endpackage

/* design/tcw_mul.sv */
module tcw_mul (
  input  logic                   clk,
  input  logic                   en,
  input  logic [tcw_pkg::MW-1:0] a,
  input  logic [tcw_pkg::MW-1:0] b,
  output logic [tcw_pkg::SW-1:0] p
);
  import tcw_pkg::*;

  localparam int HW = MW / 2;

  logic [2*HW-1:0] pp00, pp01, pp10, pp11;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a[HW-1:0] * b[HW-1:0];
      pp01 <= a[HW-1:0] * b[MW-1:HW];
      pp10 <= a[MW-1:HW] * b[HW-1:0];
      pp11 <= a[MW-1:HW] * b[MW-1:HW];
      p <= SW'(pp00) + ((SW'(pp01) + SW'(pp10)) << HW) + (SW'(pp11) << (2 * HW));
    end
  end

endmodule

/* design/tcw_cot.sv */
module tcw_cot (
  input  logic                   clk,
  input  logic                   en,
  input  logic [tcw_pkg::SW-1:0] d2,
  input  logic [tcw_pkg::SW-1:0] s,
  input  logic                   neg,
  output logic signed [31:0]     cot
);
  import tcw_pkg::*;

  localparam int QW = DivSteps + 1;
  localparam int NW = SW + 32;

  typedef struct packed {
    logic                sat;
    logic                neg;
    logic [SW-1:0]       s;
    logic [SW-1:0]       r;
    logic [DivSteps-1:0] nb;
    logic [DivSteps-1:0] q;
  } div_t;

  typedef struct packed {
    logic          neg;
    logic [QW-1:0] x;
    logic [QW-1:0] res;
  } sq_t;

  function automatic div_t div_step(div_t d);
    logic [SW:0] r2;
    logic        ge;
    div_t        o;
    r2 = {d.r, d.nb[DivSteps-1]};
    ge = r2 >= {1'b0, d.s};
    o = d;
    o.r = ge ? SW'(r2 - {1'b0, d.s}) : r2[SW-1:0];
    o.nb = {d.nb[DivSteps-2:0], 1'b0};
    o.q = {d.q[DivSteps-2:0], ge};
    return o;
  endfunction

  function automatic sq_t sq_step(sq_t d, int j);
    logic [QW:0] bitv;
    logic [QW:0] t;
    sq_t         o;
    bitv = (QW+1)'(1) << (QW - 1 - 2 * j);
    t = {1'b0, d.res} + bitv;
    o = d;
    if ({1'b0, d.x} >= t) begin
      o.x = QW'({1'b0, d.x} - t);
      o.res = QW'((d.res >> 1) + bitv);
    end else begin
      o.res = d.res >> 1;
    end
    return o;
  endfunction

  logic [NW-1:0] n;
  div_t          d0;
  div_t          dv [DivSteps+1];
  sq_t           q0;
  sq_t           sq [SqrtSteps];
  logic [31:0]   root;

  // The quotient is clamped at 2^62, whose root already reaches every limit.
  always_comb begin
    n = {d2, 32'b0};
    d0.sat = SW'(n[NW-1:DivSteps]) >= s;
    d0.neg = neg;
    d0.s = s;
    d0.r = SW'(n[NW-1:DivSteps]);
    d0.nb = n[DivSteps-1:0];
    d0.q = '0;
    q0.neg = dv[DivSteps].neg;
    q0.x = dv[DivSteps].sat ? (QW'(1) << (QW - 1)) : {1'b0, dv[DivSteps].q};
    q0.res = '0;
    root = sq[SqrtSteps-1].res[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= d0;
      sq[0] <= sq_step(q0, 0);
      if (sq[SqrtSteps-1].neg) begin
        cot <= 32'd0 - root;
      end else begin
        cot <= root[31] ? 32'h7FFF_FFFF : root;
      end
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= div_step(dv[i]);
      end
    end
  end

  for (genvar j = 1; j < SqrtSteps; j++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq[j] <= sq_step(sq[j-1], j);
      end
    end
  end

endmodule

/* design/triangle_cotangent_weights.sv */
// Takes one triangle per clock while the output is not stalled and returns its three
// corner cotangents in signed Q16.16 with a status; results leave in order. Most of the
// pipeline is the three division and square-root lanes, which resolve one
// quotient bit per stage over 62 stages and one root bit per stage over 32 stages. The
// wide products go through registered split multipliers. When a result word is stalled
// the whole pipeline holds and the input is stalled; nothing is dropped or repeated.
// Registers: index 0 is min_edge_sq, index 1 is min_sine; write them only while idle.
module triangle_cotangent_weights (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     tri_valid,
  output logic                     tri_stall,
  input  tcw_pkg::tcw_in_t         tri_word,
  output logic                     cot_valid,
  input  logic                     cot_stall,
  output tcw_pkg::tcw_out_t        cot_word,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tcw_pkg::IdxW-1:0] cfg_index,
  input  logic [31:0]              cfg_data
);
  import tcw_pkg::*;

  typedef struct packed {
    logic       short_edge;
    logic [2:0] cneg;
  } sb1_t;

  typedef struct packed {
    logic               short_edge;
    logic [2:0]         cneg;
    logic [SW-1:0]      s;
    logic [2:0][SW-1:0] d2;
  } sb2_t;

  logic [31:0] min_edge_sq;
  logic [15:0] min_sine;
  logic        adv;
  logic [31:0] m2;

  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] vc [3];

  logic              v1, v2, v3, v4, v5, v6;
  logic signed [32:0] ab [3];
  logic signed [32:0] bc [3];
  logic signed [32:0] ca [3];
  logic signed [65:0] sqa [3];
  logic signed [65:0] sqb [3];
  logic signed [65:0] sqc [3];
  logic signed [65:0] x1 [3];
  logic signed [65:0] x2 [3];
  logic signed [65:0] dpa [3];
  logic signed [65:0] dpb [3];
  logic signed [65:0] dpc [3];
  logic [MW-1:0]      nn3 [3];
  logic signed [65:0] xs [3];
  logic signed [66:0] dot [3];
  logic [MW-1:0]      nn4 [3];
  logic [MW-2:0]      xm [3];
  logic [MW-1:0]      dm [3];
  logic [2:0]         cneg4;
  logic               short4;

  logic [SW-1:0] xsq [3];
  logic [SW-1:0] npr [3];
  logic [SW-1:0] dsq [3];
  logic [SW-1:0] pp5 [3];
  logic [SW-1:0] lo [3];
  logic [SW-1:0] hi [3];

  logic       sv1 [MulLat];
  sb1_t       sd1 [MulLat];
  sb2_t       s5;
  logic       sv2 [MulLat];
  sb2_t       sd2 [MulLat];
  logic [2:0] sine_low;
  logic [1:0] status_next;
  logic [1:0] status6;
  logic [2:0] cneg6;
  logic [SW-1:0] s6;
  logic [SW-1:0] d26 [3];
  logic       sv3 [CotLat];
  logic [1:0] sd3 [CotLat];
  logic signed [31:0] cot [3];

  assign adv = !cot_valid || !cot_stall;
  assign tri_stall = !adv;
  assign cfg_ready = 1'b1;
  assign m2 = min_sine * min_sine;

  assign va[0] = tri_word.ax;
  assign va[1] = tri_word.ay;
  assign va[2] = tri_word.az;
  assign vb[0] = tri_word.bx;
  assign vb[1] = tri_word.by;
  assign vb[2] = tri_word.bz;
  assign vc[0] = tri_word.cx;
  assign vc[1] = tri_word.cy;
  assign vc[2] = tri_word.cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_edge_sq <= 32'd1;
      min_sine <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_EDGE_SQ: min_edge_sq <= cfg_data;
        REG_MIN_SINE:    min_sine <= cfg_data[15:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      cot_valid <= 1'b0;
    end else if (adv) begin
      v1 <= tri_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= sv1[MulLat-1];
      v6 <= sv2[MulLat-1];
      cot_valid <= sv3[CotLat-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int I = (k + 1) % 3;
    localparam int J = (k + 2) % 3;

    always_ff @(posedge clk) begin
      if (adv) begin
        ab[k] <= $signed({vb[k][31], vb[k]}) - $signed({va[k][31], va[k]});
        bc[k] <= $signed({vc[k][31], vc[k]}) - $signed({vb[k][31], vb[k]});
        ca[k] <= $signed({va[k][31], va[k]}) - $signed({vc[k][31], vc[k]});
        sqa[k] <= ab[k] * ab[k];
        sqb[k] <= bc[k] * bc[k];
        sqc[k] <= ca[k] * ca[k];
        x1[k] <= ab[I] * bc[J];
        x2[k] <= ab[J] * bc[I];
        dpa[k] <= ca[k] * ab[k];
        dpb[k] <= ab[k] * bc[k];
        dpc[k] <= bc[k] * ca[k];
        xs[k] <= x1[k] - x2[k];
        xm[k] <= xs[k][65] ? (MW-1)'(-xs[k]) : (MW-1)'(xs[k]);
        dm[k] <= dot[k][66] ? MW'(-dot[k]) : MW'(dot[k]);
        cneg4[k] <= !dot[k][66] && (dot[k] != '0);
        nn4[k] <= nn3[k];
        pp5[k] <= npr[k];
      end
    end

    tcw_mul u_xsq (
      .clk(clk), .en(adv), .a({1'b0, xm[k]}), .b({1'b0, xm[k]}), .p(xsq[k])
    );
    tcw_mul u_npr (
      .clk(clk), .en(adv), .a(nn4[k]), .b(nn4[I]), .p(npr[k])
    );
    tcw_mul u_dsq (
      .clk(clk), .en(adv), .a(dm[k]), .b(dm[k]), .p(dsq[k])
    );
    tcw_mul u_lo (
      .clk(clk), .en(adv), .a(MW'(m2)), .b(pp5[k][MW-1:0]), .p(lo[k])
    );
    tcw_mul u_hi (
      .clk(clk), .en(adv), .a(MW'(m2)), .b(pp5[k][SW-1:MW]), .p(hi[k])
    );

    assign sine_low[k] = {sd2[MulLat-1].s, 32'b0} <
                         ((SW+32)'(lo[k]) + ((SW+32)'(hi[k]) << MW));

    tcw_cot u_cot (
      .clk(clk), .en(adv), .d2(d26[k]), .s(s6), .neg(cneg6[k]), .cot(cot[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nn3[0] <= MW'(sqa[0]) + MW'(sqa[1]) + MW'(sqa[2]);
      nn3[1] <= MW'(sqb[0]) + MW'(sqb[1]) + MW'(sqb[2]);
      nn3[2] <= MW'(sqc[0]) + MW'(sqc[1]) + MW'(sqc[2]);
      dot[0] <= dpa[0] + dpa[1] + dpa[2];
      dot[1] <= dpb[0] + dpb[1] + dpb[2];
      dot[2] <= dpc[0] + dpc[1] + dpc[2];
      short4 <= (nn3[0] == '0) || (nn3[0] < MW'(min_edge_sq)) ||
                (nn3[1] == '0) || (nn3[1] < MW'(min_edge_sq)) ||
                (nn3[2] == '0) || (nn3[2] < MW'(min_edge_sq));
    end
  end

  // Side data waits beside the multipliers and the cotangent lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MulLat; i++) begin
        sv1[i] <= 1'b0;
        sv2[i] <= 1'b0;
      end
      for (int i = 0; i < CotLat; i++) begin
        sv3[i] <= 1'b0;
      end
    end else if (adv) begin
      sv1[0] <= v4;
      sv2[0] <= v5;
      sv3[0] <= v6;
      for (int i = 1; i < MulLat; i++) begin
        sv1[i] <= sv1[i-1];
        sv2[i] <= sv2[i-1];
      end
      for (int i = 1; i < CotLat; i++) begin
        sv3[i] <= sv3[i-1];
      end
    end
  end

  always_comb begin
    if (sd2[MulLat-1].short_edge) begin
      status_next = ST_SHORT;
    end else if (sd2[MulLat-1].s == '0) begin
      status_next = ST_COS;
    end else if (sine_low != 3'b000) begin
      status_next = ST_SINE;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1[0] <= '{short_edge: short4, cneg: cneg4};
      for (int i = 1; i < MulLat; i++) begin
        sd1[i] <= sd1[i-1];
        sd2[i] <= sd2[i-1];
      end
      s5.short_edge <= sd1[MulLat-1].short_edge;
      s5.cneg <= sd1[MulLat-1].cneg;
      s5.s <= xsq[0] + xsq[1] + xsq[2];
      for (int i = 0; i < 3; i++) begin
        s5.d2[i] <= dsq[i];
        d26[i] <= sd2[MulLat-1].d2[i];
      end
      sd2[0] <= s5;
      status6 <= status_next;
      cneg6 <= sd2[MulLat-1].cneg;
      s6 <= sd2[MulLat-1].s;
      sd3[0] <= status6;
      for (int i = 1; i < CotLat; i++) begin
        sd3[i] <= sd3[i-1];
      end
      cot_word.status <= sd3[CotLat-1];
      if (sd3[CotLat-1] == ST_OK) begin
        cot_word.cot_at_a <= cot[0];
        cot_word.cot_at_b <= cot[1];
        cot_word.cot_at_c <= cot[2];
      end else begin
        cot_word.cot_at_a <= '0;
        cot_word.cot_at_b <= '0;
        cot_word.cot_at_c <= '0;
      end
    end
  end

endmodule

/* design/tcw_check.sv */
module tcw_check (
  input logic              clk,
  input logic              rst,
  input logic              tri_stall,
  input logic              cot_valid,
  input logic              cot_stall,
  input tcw_pkg::tcw_out_t cot_word
);
  import tcw_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !cot_valid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    cot_valid && cot_stall |=> cot_valid && $stable(cot_word))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    cot_valid && (cot_word.status != ST_OK) |->
      (cot_word.cot_at_a == '0) && (cot_word.cot_at_b == '0) &&
      (cot_word.cot_at_c == '0))
    else $error("failed triangle carries nonzero weights");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    tri_stall |-> cot_valid && cot_stall)
    else $error("input stalled while the output is free");

endmodule

bind triangle_cotangent_weights tcw_check u_tcw_check (.*);

/* tb/sv/tb_triangle_cotangent_weights.sv */
module tb_triangle_cotangent_weights;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  typedef logic signed [255:0] big_t;

  localparam logic [IdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IdxW-1:0] REG_SPARE_3 = 2'd3;
  localparam int DRAIN_CYCLES = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tri_valid = 1'b0;
  logic tri_stall;
  tcw_in_t tri_word = '0;
  logic cot_valid;
  logic cot_stall = 1'b0;
  tcw_out_t cot_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] edge_min = 32'd1;
  logic [15:0] sine_min = 16'd1;

  tcw_out_t weights_q[$];
  int err_count = 0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int hold_cycles = 0;

  triangle_cotangent_weights uut (
    .clk(clk),
    .rst(rst),
    .tri_valid(tri_valid),
    .tri_stall(tri_stall),
    .tri_word(tri_word),
    .cot_valid(cot_valid),
    .cot_stall(cot_stall),
    .cot_word(cot_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] corner_cot(big_t d, big_t s);
    logic neg;
    big_t mag, limit, rhs, q, tq, one;
    neg = d > 0;
    mag = (d < 0) ? -d : d;
    one = 1;
    limit = neg ? (one <<< 31) : (one <<< 31) - 1;
    rhs = (mag * mag) <<< 32;
    q = 0;
    for (int bit_i = 31; bit_i >= 0; bit_i--) begin
      tq = q | (one <<< bit_i);
      if (tq <= limit && tq * tq * s <= rhs) begin
        q = tq;
      end
    end
    if (neg) begin
      q = -q;
    end
    return q[31:0];
  endfunction

  function automatic logic sine_short(big_t s, big_t n1, big_t n2);
    big_t m;
    m = {240'd0, sine_min};
    return (s <<< 32) < m * m * n1 * n2;
  endfunction

  function automatic tcw_out_t cot_weights(tcw_in_t t);
    big_t a[3], b[3], c[3], ab[3], bc[3], ca[3], x[3];
    big_t nab, nbc, nca, s, lim, d_a, d_b, d_c;
    tcw_out_t r;
    int i, j;
    r = '0;
    a[0] = t.ax; a[1] = t.ay; a[2] = t.az;
    b[0] = t.bx; b[1] = t.by; b[2] = t.bz;
    c[0] = t.cx; c[1] = t.cy; c[2] = t.cz;
    for (int k = 0; k < 3; k++) begin
      ab[k] = b[k] - a[k];
      bc[k] = c[k] - b[k];
      ca[k] = a[k] - c[k];
    end
    nab = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
    nbc = bc[0] * bc[0] + bc[1] * bc[1] + bc[2] * bc[2];
    nca = ca[0] * ca[0] + ca[1] * ca[1] + ca[2] * ca[2];
    lim = {224'd0, edge_min};
    if (nab == 0 || nab < lim || nbc == 0 || nbc < lim || nca == 0 || nca < lim) begin
      r.status = ST_SHORT;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      x[k] = ab[i] * bc[j] - ab[j] * bc[i];
    end
    s = x[0] * x[0] + x[1] * x[1] + x[2] * x[2];
    if (s == 0) begin
      r.status = ST_COS;
      return r;
    end
    if (sine_min != 0 && (sine_short(s, nab, nbc) || sine_short(s, nbc, nca) ||
        sine_short(s, nca, nab))) begin
      r.status = ST_SINE;
      return r;
    end
    d_a = ca[0] * ab[0] + ca[1] * ab[1] + ca[2] * ab[2];
    d_b = ab[0] * bc[0] + ab[1] * bc[1] + ab[2] * bc[2];
    d_c = bc[0] * ca[0] + bc[1] * ca[1] + bc[2] * ca[2];
    r.cot_at_a = corner_cot(d_a, s);
    r.cot_at_b = corner_cot(d_b, s);
    r.cot_at_c = corner_cot(d_c, s);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic tcw_in_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz);
    tcw_in_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    return t;
  endfunction

  function automatic int near(int center, int span_log);
    int off;
    off = $urandom & ((32'd1 << span_log) - 1);
    return center + (($urandom_range(0, 1) == 1) ? off : -off);
  endfunction

  // Mostly clustered triangles at a random scale so every check can trip.
  function automatic tcw_in_t rand_tri();
    tcw_in_t t;
    int cen[3], d[3], sc, mode;
    mode = $urandom_range(0, 9);
    sc = $urandom_range(0, 30);
    for (int k = 0; k < 3; k++) begin
      cen[k] = $urandom;
    end
    if (mode == 0) begin
      t = tcw_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom});
    end else if (mode == 1) begin
      for (int k = 0; k < 3; k++) begin
        d[k] = near(0, sc > 28 ? 28 : sc);
      end
      t = mk_tri(cen[0], cen[1], cen[2], cen[0] + d[0], cen[1] + d[1], cen[2] + d[2],
                 cen[0] + 2 * d[0], cen[1] + 2 * d[1], cen[2] + 2 * d[2]);
      if ($urandom_range(0, 1) == 1) begin
        t.cz = t.cz + $urandom_range(1, 3);
      end
    end else if (mode == 2) begin
      t = mk_tri(cen[0], cen[1], cen[2], near(cen[0], sc), near(cen[1], sc),
                 near(cen[2], sc), cen[0], cen[1], cen[2]);
      t.cx = t.cx + $urandom_range(0, 2);
    end else begin
      t = mk_tri(near(cen[0], sc), near(cen[1], sc), near(cen[2], sc),
                 near(cen[0], sc), near(cen[1], sc), near(cen[2], sc),
                 near(cen[0], sc), near(cen[1], sc), near(cen[2], sc));
    end
    return t;
  endfunction

  task automatic send_tri(input tcw_in_t t);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      tri_valid <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
    @(negedge clk);
    tri_valid <= 1'b1;
    tri_word <= t;
    do @(posedge clk); while (tri_stall);
    weights_q.push_back(cot_weights(t));
  endtask

  task automatic end_input();
    @(negedge clk);
    tri_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_input();
    wait (weights_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MIN_EDGE_SQ) begin
      edge_min = val;
    end else if (idx == REG_MIN_SINE) begin
      sine_min = val[15:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(mk_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    send_tri(mk_tri(0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h1bb68, 0));
    send_tri(mk_tri(0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0));
    send_tri(mk_tri(0, 0, 0, 32'h10000, 0, 0, 32'h8000, 32'h800, 0));
    send_tri(mk_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 0));
    send_tri(mk_tri(32'h80000000, 0, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'h80000000, 0));
    send_tri(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_tri(mk_tri(5, 5, 5, 5, 5, 5, 9, 9, 9));
    write_reg(REG_MIN_SINE, 32'd0);
    write_reg(REG_MIN_EDGE_SQ, 32'd0);
    send_tri(mk_tri(0, 0, 0, 32'h7fff0000, 0, 0, 32'h3fff8000, 1, 0));
    send_tri(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_tri(mk_tri(0, 0, 0, 32'h7fffffff, 1, 0, 32'h80000000, 0, 1));
    write_reg(REG_MIN_SINE, 32'hffff);
    write_reg(REG_MIN_EDGE_SQ, 32'hffffffff);
    send_tri(mk_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    send_tri(mk_tri(0, 0, 0, 32'h1000, 0, 0, 0, 32'h1000, 0));
    send_tri(mk_tri(0, 0, 0, 32'h100000, 0, 0, 32'h80000, 32'h100, 0));
    write_reg(REG_SPARE_2, 32'h0);
    write_reg(REG_SPARE_3, 32'h0);
    send_tri(mk_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
  endtask

  task automatic test_config_sweep();
    logic [31:0] edges[4];
    logic [15:0] sines[4];
    edges = '{32'd0, 32'hffffffff, 32'd1, 32'd0};
    sines = '{16'd0, 16'hffff, 16'd1, 16'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MIN_EDGE_SQ, p < 4 ? edges[p] : $urandom);
      write_reg(REG_MIN_SINE, p < 4 ? 32'(sines[p]) : 32'($urandom_range(0, 65535)));
      repeat (60) send_tri(rand_tri());
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_MIN_EDGE_SQ, $urandom_range(0, 4096));
    write_reg(REG_MIN_SINE, $urandom_range(0, 200));
    in_gaps = 1'b0;
    @(negedge clk);
    hold_cycles = 400;
    repeat (200) send_tri(rand_tri());
    in_gaps = 1'b1;
    end_input();
    wait (weights_q.size() == 0);
    repeat (100) send_tri(rand_tri());
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_MIN_EDGE_SQ, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024));
      write_reg(REG_MIN_SINE, $urandom_range(0, 2) == 0 ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 64));
      repeat (130) send_tri(rand_tri());
    end
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    repeat (120) send_tri(rand_tri());
  endtask

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        cot_stall <= 1'b1;
      end else begin
        if (out_gaps && burst == 0 && $urandom_range(0, 5) == 0) begin
          burst = $urandom_range(1, 14);
        end
        if (burst > 0) begin
          burst--;
          cot_stall <= 1'b1;
        end else begin
          cot_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tcw_out_t want;
    if (!rst && cot_valid && !cot_stall) begin
      if (weights_q.size() == 0) begin
        err_count++;
        $display("%t: unexpected result word %h", $time, cot_word);
      end else begin
        want = weights_q.pop_front();
        if (cot_word.cot_at_a !== want.cot_at_a) begin
          err_count++;
          $display("%t: cot_at_a expected %h actual %h", $time, want.cot_at_a,
                   cot_word.cot_at_a);
        end
        if (cot_word.cot_at_b !== want.cot_at_b) begin
          err_count++;
          $display("%t: cot_at_b expected %h actual %h", $time, want.cot_at_b,
                   cot_word.cot_at_b);
        end
        if (cot_word.cot_at_c !== want.cot_at_c) begin
          err_count++;
          $display("%t: cot_at_c expected %h actual %h", $time, want.cot_at_c,
                   cot_word.cot_at_c);
        end
        if (cot_word.status !== want.status) begin
          err_count++;
          $display("%t: status expected %0d actual %0d", $time, want.status,
                   cot_word.status);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait_drained();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tcw_pkg.sv
design/tcw_mul.sv
design/tcw_cot.sv
design/triangle_cotangent_weights.sv
design/tcw_check.sv
tb/sv/tb_triangle_cotangent_weights.sv
